/* rtl/firs_pkg.sv */
// Shared constants and types for the streaming FIR filter.
`timescale 1ns / 1ps
`default_nettype none

package firs_pkg;

    localparam int TAPS_DEF        = 401;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 18;

    localparam int          SHIFT_W     = 5;
    localparam logic [4:0]  SHIFT_RESET = 5'd16;

    localparam logic OP_WRITE_TAP = 1'b0;
    localparam logic OP_SAMPLE    = 1'b1;

    typedef struct packed {
        logic start;
        logic rd_vld;
        logic zero;
        logic last;
    } mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/firs_ram.sv */
// Single-write, single-read synchronous memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module firs_ram #(
    parameter int WIDTH = firs_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = firs_pkg::TAPS_DEF,
    parameter int AW    = 9
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/firs_mac.sv */
// Multiply-accumulate datapath with rounding, shift and saturation.
`timescale 1ns / 1ps
`default_nettype none

module firs_mac #(
    parameter int TAPS        = firs_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = firs_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = firs_pkg::COEF_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  firs_pkg::mac_ctl_t            ctl,
    input  logic signed [COEF_BITS-1:0]   coef,
    input  logic signed [SAMPLE_BITS-1:0] smp,
    input  logic [firs_pkg::SHIFT_W-1:0]  shift,
    input  logic                          res_take,
    output logic                          res_valid,
    output logic [SAMPLE_BITS-1:0]        res_filtered,
    output logic                          res_saturated
);

    localparam int PW     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PW + $clog2(TAPS) + 1;
    localparam int RW     = ((ACC_W > 32) ? ACC_W : 32) + 1;
    localparam logic signed [RW-1:0] MAXV = RW'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

    firs_pkg::mac_ctl_t        ctl_d_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      prod_next;
    logic                      prod_vld_reg;
    logic                      prod_last_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      sum_done_reg;
    logic signed [RW-1:0]      rnd_reg;
    logic [RW-1:0]             rnd_const;
    logic                      rnd_vld_reg;
    logic signed [RW-1:0]      shifted;
    logic                      res_vld_reg;
    logic [SAMPLE_BITS-1:0]    res_filt_reg;
    logic [SAMPLE_BITS-1:0]    res_filt_next;
    logic                      res_sat_reg;
    logic                      res_sat_next;

    assign prod_next = ctl_d_reg.zero ? '0 : PW'(coef * smp);
    assign rnd_const = ({{(RW-1){1'b0}}, 1'b1} << shift) >> 1;
    assign shifted   = rnd_reg >>> shift;

    always_comb
    begin
        res_sat_next  = 1'b0;
        res_filt_next = shifted[SAMPLE_BITS-1:0];
        if (shifted > MAXV)
        begin
            res_sat_next  = 1'b1;
            res_filt_next = MAXV[SAMPLE_BITS-1:0];
        end
        else if (shifted < MINV)
        begin
            res_sat_next  = 1'b1;
            res_filt_next = MINV[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg     <= '0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            sum_done_reg  <= 1'b0;
            rnd_vld_reg   <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            ctl_d_reg     <= ctl;
            prod_vld_reg  <= ctl_d_reg.rd_vld;
            prod_last_reg <= ctl_d_reg.rd_vld && ctl_d_reg.last;
            sum_done_reg  <= prod_vld_reg && prod_last_reg;
            rnd_vld_reg   <= sum_done_reg;
            if (rnd_vld_reg)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (res_take)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl.start)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (sum_done_reg)
        begin
            rnd_reg <= RW'(acc_reg) + $signed(rnd_const);
        end
        if (rnd_vld_reg)
        begin
            res_filt_reg <= res_filt_next;
            res_sat_reg  <= res_sat_next;
        end
    end

    assign res_valid     = res_vld_reg;
    assign res_filtered  = res_filt_reg;
    assign res_saturated = res_sat_reg;

endmodule

`default_nettype wire

/* rtl/fir_filter_stream.sv */
// Top level of the streaming direct-form FIR filter.
`timescale 1ns / 1ps
`default_nettype none

// A write-tap item leaves the input open and writes one coefficient into the
// coefficient memory when its tap index is below TAPS. The next item after a
// sample is taken once the previous result has left the computation: one
// shared multiply-accumulate reads one tap a cycle from the coefficient and
// delay-line memories, followed by a short product, sum, rounding and
// saturation pipeline. The result sits in an output register, so the next
// item is taken while it waits. The delay line needs no clearing after reset;
// a fill count makes taps older than the stream read as zero. Coefficients
// read before they are written are undefined.
module fir_filter_stream #(
    parameter int TAPS        = firs_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = firs_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = firs_pkg::COEF_BITS_DEF,
    parameter int IDX_W       = (TAPS > 1) ? $clog2(TAPS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [IDX_W-1:0]              tap_index,
    input  logic signed [COEF_BITS-1:0]   coefficient,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [firs_pkg::SHIFT_W-1:0]  cfg_data
);

    localparam int FW = $clog2(TAPS + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [IDX_W-1:0]             newest_reg;
    logic [IDX_W-1:0]             newest_next;
    logic [IDX_W-1:0]             j_reg;
    logic [IDX_W-1:0]             j_next;
    logic [IDX_W-1:0]             k_reg;
    logic [IDX_W-1:0]             k_next;
    logic [FW-1:0]                fill_reg;
    logic [FW-1:0]                fill_next;
    logic [firs_pkg::SHIFT_W-1:0] output_shift_reg;
    logic                         out_valid_reg;
    logic [SAMPLE_BITS-1:0]       filtered_reg;
    logic                         saturated_reg;

    logic                         in_xfer;
    logic                         smp_xfer;
    logic                         coef_we;
    logic [IDX_W-1:0]             pos;
    logic                         last_tap;
    firs_pkg::mac_ctl_t           ctl;
    logic [COEF_BITS-1:0]         coef_rd;
    logic [SAMPLE_BITS-1:0]       smp_rd;
    logic                         res_valid;
    logic [SAMPLE_BITS-1:0]       res_filtered;
    logic                         res_saturated;
    logic                         res_take;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign smp_xfer  = in_xfer && (opcode == firs_pkg::OP_SAMPLE);
    assign coef_we   = in_xfer && (opcode == firs_pkg::OP_WRITE_TAP)
                       && ({1'b0, tap_index} < (IDX_W + 1)'(TAPS));
    assign pos       = (newest_reg == IDX_W'(TAPS - 1)) ? '0 : newest_reg + 1'b1;
    assign last_tap  = (j_reg == IDX_W'(TAPS - 1));
    assign cfg_ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        ctl.start  = smp_xfer;
        ctl.rd_vld = (state_reg == ST_RUN);
        ctl.zero   = (FW'(j_reg) >= fill_reg);
        ctl.last   = last_tap;
    end

    always_comb
    begin
        state_next  = state_reg;
        newest_next = newest_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        fill_next   = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (smp_xfer)
                begin
                    newest_next = pos;
                    k_next      = pos;
                    j_next      = '0;
                    if (fill_reg < FW'(TAPS))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                j_next = j_reg + 1'b1;
                k_next = (k_reg == '0) ? IDX_W'(TAPS - 1) : k_reg - 1'b1;
                if (last_tap)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            newest_reg       <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            fill_reg         <= '0;
            output_shift_reg <= firs_pkg::SHIFT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            fill_reg   <= fill_next;
            if (cfg_valid && cfg_ready)
            begin
                output_shift_reg <= cfg_data;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            filtered_reg  <= res_filtered;
            saturated_reg <= res_saturated;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign saturated = saturated_reg;

    firs_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (TAPS),
        .AW    (IDX_W)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (tap_index),
        .wdata (coefficient),
        .raddr (j_reg),
        .rdata (coef_rd)
    );

    firs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS),
        .AW    (IDX_W)
    ) u_delay_ram (
        .clk   (clk),
        .we    (smp_xfer),
        .waddr (pos),
        .wdata (sample),
        .raddr (k_reg),
        .rdata (smp_rd)
    );

    firs_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .coef          ($signed(coef_rd)),
        .smp           ($signed(smp_rd)),
        .shift         (output_shift_reg),
        .res_take      (res_take),
        .res_valid     (res_valid),
        .res_filtered  (res_filtered),
        .res_saturated (res_saturated)
    );

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !res_valid)
        else $error("result pending while input side is open");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (state_reg == ST_WAIT))
        else $error("result produced outside the wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(TAPS))
        else $error("fill count beyond tap count");

    assert property (@(posedge clk) disable iff (!rst_n)
        smp_xfer |=> (newest_reg < IDX_W'(TAPS)) && (k_reg == newest_reg))
        else $error("delay line pointer out of range");
`endif

endmodule

`default_nettype wire

/* sim/fir_filter_stream_tb.sv */
// Self-checking testbench for the streaming FIR filter, checked against a tap-sum predictor.
`timescale 1ns / 1ps

module fir_filter_stream_tb;

    localparam int TAPS          = firs_pkg::TAPS_DEF;
    localparam int SB            = firs_pkg::SAMPLE_BITS_DEF;
    localparam int CB            = firs_pkg::COEF_BITS_DEF;
    localparam int SW            = firs_pkg::SHIFT_W;
    localparam int IDX_W         = $clog2(TAPS);
    localparam int SETTLE_CYCLES = TAPS + 8;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 107;
    localparam int DIRECTED_ROWS = 20;
    localparam int MAX_REPORTS   = 10;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam longint OUT_MAX   = (longint'(1) << (SB - 1)) - 1;
    localparam longint OUT_MIN   = -OUT_MAX - 1;

    typedef struct packed {
        logic signed [SB-1:0] value;
        logic                 clipped;
    } fir_out_t;

    typedef struct packed {
        logic                 op;
        logic [IDX_W-1:0]     idx;
        logic signed [CB-1:0] coef;
        logic signed [SB-1:0] smp;
        logic                 typed;
        logic signed [SB-1:0] want;
        logic                 want_sat;
    } step_row_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 opcode      = firs_pkg::OP_WRITE_TAP;
    logic [IDX_W-1:0]     tap_index   = '0;
    logic signed [CB-1:0] coefficient = '0;
    logic signed [SB-1:0] sample      = '0;
    logic                 out_stall   = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [SW-1:0]        cfg_data    = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic signed [SB-1:0] filtered;
    logic                 saturated;
    logic                 cfg_ready;

    logic signed [CB-1:0] tap_values [TAPS];
    logic signed [SB-1:0] history [TAPS];
    int                   newest_slot = 0;
    logic [SW-1:0]        shift_now = firs_pkg::SHIFT_RESET;
    fir_out_t             pending_outputs [$];
    step_row_t            directed_rows [DIRECTED_ROWS];
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   mismatches = 0;
    longint               cycle_count = 0;

    fir_filter_stream dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .tap_index   (tap_index),
        .coefficient (coefficient),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .filtered    (filtered),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic fir_out_t filter_sample(input logic signed [SB-1:0] smp);
        fir_out_t res;
        longint   acc;
        int       j;
        int       k;
        newest_slot = (newest_slot + 1) % TAPS;
        history[newest_slot] = smp;
        acc = 0;
        for (j = 0; j < TAPS; j++)
        begin
            k = (newest_slot >= j) ? newest_slot - j : newest_slot + TAPS - j;
            acc += longint'(tap_values[j]) * longint'(history[k]);
        end
        if (shift_now != 0)
            acc += longint'(1) << (shift_now - 1);
        acc = acc >>> shift_now;
        res.clipped = 1'b1;
        if (acc > OUT_MAX)
            res.value = OUT_MAX[SB-1:0];
        else if (acc < OUT_MIN)
            res.value = OUT_MIN[SB-1:0];
        else
        begin
            res.value = acc[SB-1:0];
            res.clipped = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : check_outputs
        fir_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
                note_mismatch($sformatf("unexpected result filtered=%0d saturated=%0b",
                                        filtered, saturated));
            else
            begin
                want = pending_outputs.pop_front();
                if (filtered !== want.value || saturated !== want.clipped)
                    note_mismatch($sformatf("filtered exp %0d got %0d, saturated exp %0b got %0b",
                                            want.value, filtered, want.clipped, saturated));
            end
        end
    end

    task automatic send_item(input step_row_t row);
        fir_out_t res;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        opcode      = row.op;
        tap_index   = row.idx;
        coefficient = row.coef;
        sample      = row.smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (row.op == firs_pkg::OP_WRITE_TAP)
        begin
            if (row.idx < TAPS)
                tap_values[row.idx] = row.coef;
        end
        else
        begin
            res = filter_sample(row.smp);
            if (row.typed)
            begin
                res.value   = row.want;
                res.clipped = row.want_sat;
            end
            pending_outputs.push_back(res);
        end
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_shift(input logic [SW-1:0] value);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shift_now = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        int        i;
        int        p;
        int        send_gap [PHASES];
        int        recv_hold [PHASES];
        step_row_t row;
        logic [31:0] raw;
        logic [31:0] raw_smp;
        send_gap  = '{0, 75, 0, 26};
        recv_hold = '{0, 0, 75, 26};
        for (i = 0; i < TAPS; i++)
        begin
            tap_values[i] = '0;
            history[i]    = '0;
        end
        // op, tap, coefficient, sample, typed, filtered, saturated
        directed_rows = '{
            '{firs_pkg::OP_WRITE_TAP, 0, 65536, 0, 0, 0, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, 32767, 1, 32767, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, -32768, 1, -32768, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, 0, 1, 0, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, 1, 1, 1, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, -1, 1, -1, 0},
            '{firs_pkg::OP_WRITE_TAP, 0, 131071, 0, 0, 0, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, 32767, 1, 32767, 1},
            '{firs_pkg::OP_SAMPLE, 0, 0, -32768, 1, -32768, 1},
            '{firs_pkg::OP_WRITE_TAP, 0, -131072, 0, 0, 0, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, 32767, 1, -32768, 1},
            '{firs_pkg::OP_SAMPLE, 0, 0, -32768, 1, 32767, 1},
            '{firs_pkg::OP_WRITE_TAP, 0, 0, 0, 0, 0, 0},
            '{firs_pkg::OP_WRITE_TAP, 400, 65536, 0, 0, 0, 0},
            '{firs_pkg::OP_WRITE_TAP, 401, 12345, 0, 0, 0, 0},
            '{firs_pkg::OP_WRITE_TAP, 511, -1, 0, 0, 0, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, 100, 0, 0, 0},
            '{firs_pkg::OP_WRITE_TAP, 1, 32768, 0, 0, 0, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, -5, 0, 0, 0},
            '{firs_pkg::OP_SAMPLE, 0, 0, 12, 0, 0, 0}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // load every tap before the first sample
        for (i = 0; i < TAPS; i++)
        begin
            row     = '0;
            row.op  = firs_pkg::OP_WRITE_TAP;
            row.idx = IDX_W'(i);
            send_item(row);
        end

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_item(directed_rows[i]);

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_shift(SW'(0));
                1: write_shift(SW'(31));
                2: write_shift(SW'($urandom_range(30, 1)));
                default: write_shift(SW'($urandom_range(31)));
            endcase
            idle_pct  = send_gap[p];
            stall_pct = recv_hold[p];
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 || $urandom_range(99) == 0)
                    drain_outputs();
                raw      = $urandom;
                raw_smp  = $urandom;
                row      = '0;
                row.op   = ($urandom_range(99) < 30) ? firs_pkg::OP_WRITE_TAP
                                                     : firs_pkg::OP_SAMPLE;
                row.idx  = IDX_W'(($urandom_range(19) == 0) ? $urandom_range(511, TAPS)
                                                            : $urandom_range(TAPS - 1));
                row.coef = $signed(raw[CB-1:0]) >>> $urandom_range(CB - 1);
                row.smp  = $signed(raw_smp[SB-1:0])
                           >>> (($urandom_range(1) == 1) ? $urandom_range(SB - 1) : 0);
                send_item(row);
            end
        end

        drain_outputs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/firs_pkg.sv
rtl/firs_ram.sv
rtl/firs_mac.sv
rtl/fir_filter_stream.sv
sim/fir_filter_stream_tb.sv
